[hdl/slpe_pkg.sv]
`default_nettype none
package slpe_pkg;

  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 24;
  localparam int unsigned CfgFrameBits = 20;
  localparam int unsigned StepBits     = 24;
  localparam int unsigned FracBits     = 16;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_FIRST_LOOP_START  = 3'd0,
    REG_FIRST_LOOP_END    = 3'd1,
    REG_FIRST_LOOP_KIND   = 3'd2,
    REG_SECOND_LOOP_START = 3'd3,
    REG_SECOND_LOOP_END   = 3'd4,
    REG_SECOND_LOOP_KIND  = 3'd5,
    REG_SAMPLE_FRAMES     = 3'd6,
    REG_STEP_RATE         = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_FORWARD  = 2'd1,
    KIND_BIDIR    = 2'd2,
    KIND_RESERVED = 2'd3
  } loop_kind_e;

  localparam logic [StepBits-1:0] StepRateReset = 24'h010000;

  typedef struct packed {
    logic [CfgFrameBits-1:0] loop_start;
    logic [CfgFrameBits-1:0] loop_end;
    loop_kind_e              kind;
  } loop_cfg_t;

  typedef struct packed {
    logic backward;
    logic loop_sel;
    logic finished;
  } voice_flags_t;

  typedef struct packed {
    logic mode;
    logic released;
  } slpe_in_t;

  typedef struct packed {
    logic [CfgFrameBits-1:0] frame_index;
    logic [FracBits-1:0]     frame_fraction;
    logic                    reversed;
    logic                    loop_in_use;
    logic                    done_res;
    logic                    wrapped;
  } slpe_out_t;

endpackage
`default_nettype wire

[hdl/slpe_update.sv]
`default_nettype none
module slpe_update #(
  parameter int unsigned FRAME_BITS = 20
) (
  input  wire logic [FRAME_BITS-1:0]             whole_i,
  input  wire logic [slpe_pkg::FracBits-1:0]     frac_i,
  input  wire slpe_pkg::voice_flags_t            flags_i,
  input  wire logic                              mode_i,
  input  wire logic                              released_i,
  input  wire slpe_pkg::loop_cfg_t               first_loop_i,
  input  wire slpe_pkg::loop_cfg_t               second_loop_i,
  input  wire logic [slpe_pkg::CfgFrameBits-1:0] sample_frames_i,
  input  wire logic [slpe_pkg::StepBits-1:0]     step_rate_i,
  output logic [FRAME_BITS-1:0]                  whole_o,
  output logic [slpe_pkg::FracBits-1:0]          frac_o,
  output slpe_pkg::voice_flags_t                 flags_o,
  output logic                                   wrapped_o
);
  import slpe_pkg::*;

  localparam int unsigned IdxBits = (FRAME_BITS > CfgFrameBits) ? FRAME_BITS : CfgFrameBits;
  localparam int unsigned W       = IdxBits + 19;

  localparam logic signed [W-1:0] OneFrame = {{(W-17){1'b0}}, 17'h10000};
  localparam logic signed [W-1:0] OneUnit  = {{(W-1){1'b0}}, 1'b1};
  localparam logic signed [W-1:0] TopPos   =
    {{(W-FRAME_BITS-16){1'b0}}, {(FRAME_BITS+16){1'b1}}};

  logic signed [W-1:0] p_cur;
  logic signed [W-1:0] step_f;
  logic signed [W-1:0] sf_f;

  assign p_cur  = {{(W-FRAME_BITS-16){1'b0}}, whole_i, frac_i};
  assign step_f = {{(W-StepBits){1'b0}}, step_rate_i};
  assign sf_f   = {{(W-36){1'b0}}, sample_frames_i, 16'h0000};

  always_comb begin
    loop_cfg_t           lp;
    logic signed [W-1:0] ls_f;
    logic signed [W-1:0] le_f;
    logic signed [W-1:0] p;
    voice_flags_t        fl;
    logic                wr;

    lp   = flags_i.loop_sel ? second_loop_i : first_loop_i;
    ls_f = {{(W-36){1'b0}}, lp.loop_start, 16'h0000};
    le_f = {{(W-36){1'b0}}, lp.loop_end, 16'h0000};
    fl   = flags_i;
    wr   = 1'b0;
    p    = p_cur;

    if (mode_i) begin
      p  = '0;
      fl = '{backward: 1'b0, loop_sel: 1'b0, finished: 1'b0};
    end else if (!flags_i.finished && (step_rate_i != '0) && (sample_frames_i != '0)) begin
      p = flags_i.backward ? (p_cur - step_f) : (p_cur + step_f);
      if ((lp.kind != KIND_FORWARD) && (lp.kind != KIND_BIDIR)) begin
        if (p >= sf_f) begin
          fl.finished = 1'b1;
          wr          = 1'b1;
        end
      end else if (flags_i.backward) begin
        if (p <= ls_f) begin
          fl.backward = 1'b0;
          wr          = 1'b1;
          p           = (ls_f <<< 1) - p - OneUnit;
          if (p >= le_f) begin
            p = ls_f + {{(W-16){1'b0}}, p[15:0]};
          end
        end
      end else if (p >= le_f) begin
        wr = 1'b1;
        if (!flags_i.loop_sel && released_i) begin
          fl.loop_sel = 1'b1;
        end else if (lp.kind == KIND_BIDIR) begin
          fl.backward = 1'b1;
          p           = (le_f <<< 1) - p - OneUnit;
          if (p < (ls_f + OneFrame)) begin
            p = le_f + {{(W-16){1'b0}}, p[15:0]};
          end
        end else begin
          p = p - (le_f - ls_f);
          if (p >= le_f) begin
            p = ls_f + {{(W-16){1'b0}}, p[15:0]};
          end
        end
      end
      if (p < 0) begin
        p = '0;
      end else if (p > TopPos) begin
        p = TopPos;
      end
    end

    whole_o   = p[FRAME_BITS+15:16];
    frac_o    = p[15:0];
    flags_o   = fl;
    wrapped_o = wr;
  end

endmodule
`default_nettype wire

[hdl/sample_loop_position_engine_core.sv]
`default_nettype none
// Results register in out_q, or in skid_q on a stall; a full skid_q drops ready.
// Throughput: one transaction per ready cycle; the pointer update is a single add,
// compare and reflect pass between the voice state and a two-entry result buffer.
// Reset: pointer cleared, first loop selected, voice finished until a restart
// transaction; step rate 1.0, all other registers zero, result buffer empty.
module sample_loop_position_engine_core #(
  parameter int unsigned FRAME_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire slpe_pkg::slpe_in_t                   in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output slpe_pkg::slpe_out_t                       out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [slpe_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  wire logic [slpe_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import slpe_pkg::*;

  localparam int unsigned IdxBits = (FRAME_BITS > CfgFrameBits) ? FRAME_BITS : CfgFrameBits;

  loop_cfg_t                first_loop_q, second_loop_q;
  logic [CfgFrameBits-1:0]  sample_frames_q;
  logic [StepBits-1:0]      step_rate_q;

  logic [FRAME_BITS-1:0]    whole_q, whole_d;
  logic [FracBits-1:0]      frac_q, frac_d;
  voice_flags_t             flags_q, flags_d;
  logic                     wrapped_d;
  logic [IdxBits-1:0]       whole_ext;

  slpe_out_t                res_d;
  slpe_out_t                out_q, skid_q;
  logic                     out_valid_q, out_valid_d;
  logic                     skid_valid_q, skid_valid_d;
  logic                     accept, pop, out_load, skid_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_loop_q    <= '{loop_start: '0, loop_end: '0, kind: KIND_NONE};
      second_loop_q   <= '{loop_start: '0, loop_end: '0, kind: KIND_NONE};
      sample_frames_q <= '0;
      step_rate_q     <= StepRateReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FIRST_LOOP_START:  first_loop_q.loop_start  <= cfg_data_i[CfgFrameBits-1:0];
        REG_FIRST_LOOP_END:    first_loop_q.loop_end    <= cfg_data_i[CfgFrameBits-1:0];
        REG_FIRST_LOOP_KIND:   first_loop_q.kind        <= loop_kind_e'(cfg_data_i[1:0]);
        REG_SECOND_LOOP_START: second_loop_q.loop_start <= cfg_data_i[CfgFrameBits-1:0];
        REG_SECOND_LOOP_END:   second_loop_q.loop_end   <= cfg_data_i[CfgFrameBits-1:0];
        REG_SECOND_LOOP_KIND:  second_loop_q.kind       <= loop_kind_e'(cfg_data_i[1:0]);
        REG_SAMPLE_FRAMES:     sample_frames_q          <= cfg_data_i[CfgFrameBits-1:0];
        REG_STEP_RATE:         step_rate_q              <= cfg_data_i[StepBits-1:0];
        default: ;
      endcase
    end
  end

  slpe_update #(
    .FRAME_BITS(FRAME_BITS)
  ) u_update (
    .whole_i        (whole_q),
    .frac_i         (frac_q),
    .flags_i        (flags_q),
    .mode_i         (in_data_i.mode),
    .released_i     (in_data_i.released),
    .first_loop_i   (first_loop_q),
    .second_loop_i  (second_loop_q),
    .sample_frames_i(sample_frames_q),
    .step_rate_i    (step_rate_q),
    .whole_o        (whole_d),
    .frac_o         (frac_d),
    .flags_o        (flags_d),
    .wrapped_o      (wrapped_d)
  );

  assign whole_ext = IdxBits'(whole_d);

  always_comb begin
    res_d.frame_index    = whole_ext[CfgFrameBits-1:0];
    res_d.frame_fraction = frac_d;
    res_d.reversed       = flags_d.backward;
    res_d.loop_in_use    = flags_d.loop_sel;
    res_d.done_res       = flags_d.finished;
    res_d.wrapped        = wrapped_d;
  end

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    if (pop) begin
      if (skid_valid_q) begin
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (accept) begin
      if (!out_valid_q || pop) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q      <= '0;
      frac_q       <= '0;
      flags_q      <= '{backward: 1'b0, loop_sel: 1'b0, finished: 1'b1};
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        whole_q <= whole_d;
        frac_q  <= frac_d;
        flags_q <= flags_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[tb/sv/sample_loop_position_engine_core_test.sv]
`timescale 1ns / 100ps

module sample_loop_position_engine_core_test;
  import slpe_pkg::*;

  localparam int     QuietLimit     = 3000;
  localparam int     LongHoldCycles = 400;
  localparam longint OneFrame       = 65536;
  localparam longint FracMask       = 65535;
  localparam longint PosTop         = (longint'(1) << (CfgFrameBits + FracBits)) - 1;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  slpe_in_t                in_data_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  slpe_out_t               out_data_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0]  cfg_data_i  = '0;

  sample_loop_position_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  loop_cfg_t               loop_shadow [2];
  logic [CfgFrameBits-1:0] frames_shadow;
  logic [StepBits-1:0]     step_shadow;
  logic [CfgFrameBits-1:0] voice_whole;
  logic [FracBits-1:0]     voice_frac;
  voice_flags_t            voice_flags;

  slpe_in_t  queued_requests[$];
  slpe_out_t predicted_pointers[$];

  logic sender_steady   = 1'b0;
  logic sender_hold     = 1'b0;
  logic receiver_steady = 1'b0;
  logic long_hold_req   = 1'b0;

  int hold_left         = 0;
  int quiet_cycles      = 0;
  int requests_accepted = 0;
  int results_checked   = 0;
  int mismatch_count    = 0;
  int boundary_events   = 0;
  int reversed_seen     = 0;
  int second_loop_seen  = 0;
  int finished_seen     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic slpe_out_t step_voice(slpe_in_t req);
    loop_cfg_t lc;
    longint    pos;
    longint    ls;
    longint    le;
    longint    step_len;
    longint    frames_len;
    logic      hit;
    slpe_out_t res;
    hit = 1'b0;
    lc = voice_flags.loop_sel ? loop_shadow[1] : loop_shadow[0];
    ls = lc.loop_start;
    ls = ls * OneFrame;
    le = lc.loop_end;
    le = le * OneFrame;
    step_len = step_shadow;
    frames_len = frames_shadow;
    frames_len = frames_len * OneFrame;
    if (req.mode) begin
      voice_whole = '0;
      voice_frac  = '0;
      voice_flags = '0;
    end else if (!voice_flags.finished && step_shadow != 0 && frames_shadow != 0) begin
      pos = {voice_whole, voice_frac};
      if (voice_flags.backward) pos = pos - step_len;
      else pos = pos + step_len;
      if (lc.kind != KIND_FORWARD && lc.kind != KIND_BIDIR) begin
        if (pos >= frames_len) begin
          voice_flags.finished = 1'b1;
          hit = 1'b1;
        end
      end else if (voice_flags.backward) begin
        if (pos <= ls) begin
          hit = 1'b1;
          voice_flags.backward = 1'b0;
          pos = 2 * ls - pos - 1;
          if (pos >= le) pos = ls + (pos & FracMask);
        end
      end else if (pos >= le) begin
        hit = 1'b1;
        if (!voice_flags.loop_sel && req.released) begin
          voice_flags.loop_sel = 1'b1;
        end else if (lc.kind == KIND_BIDIR) begin
          voice_flags.backward = 1'b1;
          pos = 2 * le - pos - 1;
          if (pos < ls + OneFrame) pos = le + (pos & FracMask);
        end else begin
          pos = pos - (le - ls);
          if (pos >= le) pos = ls + (pos & FracMask);
        end
      end
      if (pos < 0) pos = 0;
      else if (pos > PosTop) pos = PosTop;
      voice_whole = pos[CfgFrameBits+FracBits-1:FracBits];
      voice_frac  = pos[FracBits-1:0];
    end
    res.frame_index    = voice_whole;
    res.frame_fraction = voice_frac;
    res.reversed       = voice_flags.backward;
    res.loop_in_use    = voice_flags.loop_sel;
    res.done_res       = voice_flags.finished;
    res.wrapped        = hit;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_pointers.push_back(step_voice(in_data_i));
        requests_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (queued_requests.size() != 0 && !sender_hold &&
            (sender_steady || $urandom_range(0, 99) >= 16)) begin
          in_data_i  <= queued_requests.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slpe_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_pointers.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time,
                   out_data_o);
          mismatch_count++;
        end else begin
          want = predicted_pointers.pop_front();
          check_field("frame_index", want.frame_index, out_data_o.frame_index);
          check_field("frame_fraction", want.frame_fraction, out_data_o.frame_fraction);
          check_field("reversed", want.reversed, out_data_o.reversed);
          check_field("loop_in_use", want.loop_in_use, out_data_o.loop_in_use);
          check_field("done_res", want.done_res, out_data_o.done_res);
          check_field("wrapped", want.wrapped, out_data_o.wrapped);
          results_checked++;
          boundary_events += out_data_o.wrapped;
          reversed_seen += out_data_o.reversed;
          second_loop_seen += out_data_o.loop_in_use;
          finished_seen += out_data_o.done_res;
        end
      end
      if (long_hold_req) hold_left = LongHoldCycles;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= receiver_steady || $urandom_range(0, 99) >= 16;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ns: no transaction for %0d cycles", $time, QuietLimit);
        $display("sample_loop_position_engine_core_test: done, errors");
        $finish;
      end
    end
  end

  task automatic write_register(input cfg_reg_e idx, input logic [CfgDataBits-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      REG_FIRST_LOOP_START:  loop_shadow[0].loop_start = value[CfgFrameBits-1:0];
      REG_FIRST_LOOP_END:    loop_shadow[0].loop_end   = value[CfgFrameBits-1:0];
      REG_FIRST_LOOP_KIND:   loop_shadow[0].kind       = loop_kind_e'(value[1:0]);
      REG_SECOND_LOOP_START: loop_shadow[1].loop_start = value[CfgFrameBits-1:0];
      REG_SECOND_LOOP_END:   loop_shadow[1].loop_end   = value[CfgFrameBits-1:0];
      REG_SECOND_LOOP_KIND:  loop_shadow[1].kind       = loop_kind_e'(value[1:0]);
      REG_SAMPLE_FRAMES:     frames_shadow             = value[CfgFrameBits-1:0];
      REG_STEP_RATE:         step_shadow               = value[StepBits-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid_i || predicted_pointers.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic apply_setup(input loop_cfg_t first, input loop_cfg_t second,
                             input logic [CfgFrameBits-1:0] frames,
                             input logic [StepBits-1:0] step);
    wait_drained();
    repeat (3) @(negedge clk_i);
    write_register(REG_FIRST_LOOP_START, first.loop_start);
    write_register(REG_FIRST_LOOP_END, first.loop_end);
    write_register(REG_FIRST_LOOP_KIND, first.kind);
    write_register(REG_SECOND_LOOP_START, second.loop_start);
    write_register(REG_SECOND_LOOP_END, second.loop_end);
    write_register(REG_SECOND_LOOP_KIND, second.kind);
    write_register(REG_SAMPLE_FRAMES, frames);
    write_register(REG_STEP_RATE, step);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_request(input logic restart, input logic rel);
    queued_requests.push_back(slpe_in_t'{mode: restart, released: rel});
  endtask

  function automatic loop_cfg_t random_loop();
    loop_cfg_t   lc;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) lc.kind = KIND_FORWARD;
    else if (pick < 80) lc.kind = KIND_BIDIR;
    else if (pick < 92) lc.kind = KIND_NONE;
    else lc.kind = KIND_RESERVED;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      lc.loop_start = CfgFrameBits'($urandom_range(0, 32));
      lc.loop_end   = lc.loop_start + CfgFrameBits'($urandom_range(1, 48));
    end else if (pick < 90) begin
      lc.loop_start = CfgFrameBits'($urandom_range(0, 40));
      lc.loop_end   = CfgFrameBits'($urandom_range(0, lc.loop_start));
    end else begin
      lc.loop_start = $urandom_range(0, 1) ? 20'hFFFFF : CfgFrameBits'($urandom_range(0, 20'hFFFFF));
      lc.loop_end   = $urandom_range(0, 1) ? 20'hFFFFF : CfgFrameBits'($urandom_range(0, 64));
    end
    return lc;
  endfunction

  task automatic random_setup();
    logic [CfgFrameBits-1:0] frames;
    logic [StepBits-1:0]     step;
    int unsigned             pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) frames = '0;
    else if (pick < 10) frames = 20'hFFFFF;
    else frames = CfgFrameBits'($urandom_range(1, 160));
    pick = $urandom_range(0, 99);
    if (pick < 5) step = '0;
    else if (pick < 20) step = StepBits'($urandom_range(1, 16'hFFFF));
    else if (pick < 75) step = StepBits'($urandom_range(24'h008000, 24'h060000));
    else if (pick < 92) step = 24'h010000;
    else if (pick < 95) step = 24'hFFFFFF;
    else step = StepBits'($urandom_range(24'h060000, 24'hFFFFFF));
    apply_setup(random_loop(), random_loop(), frames, step);
  endtask

  task automatic queue_voice_run(input int count);
    int n;
    int len;
    int release_at;
    int noise;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) != 0) begin
        queue_request(1'b1, 1'($urandom_range(0, 1)));
        n++;
      end
      len = $urandom_range(4, 40);
      release_at = $urandom_range(0, len);
      for (int i = 0; i < len && n < count; i++) begin
        noise = $urandom_range(0, 99);
        if (noise < 3) queue_request(1'b1, 1'($urandom_range(0, 1)));
        else if (noise < 8) queue_request(1'b0, i < release_at);
        else queue_request(1'b0, i >= release_at);
        n++;
      end
    end
  endtask

  initial begin
    loop_shadow[0] = '{loop_start: '0, loop_end: '0, kind: KIND_NONE};
    loop_shadow[1] = '{loop_start: '0, loop_end: '0, kind: KIND_NONE};
    frames_shadow  = '0;
    step_shadow    = StepRateReset;
    voice_whole    = '0;
    voice_frac     = '0;
    voice_flags    = '{backward: 1'b0, loop_sel: 1'b0, finished: 1'b1};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle after reset, then zero-length sample
    queue_request(1'b0, 1'b0);
    queue_request(1'b1, 1'b0);
    queue_request(1'b0, 1'b1);

    // no loop: finish at the sample end, then stay idle
    apply_setup('{loop_start: 20'd0, loop_end: 20'd0, kind: KIND_NONE},
                '{loop_start: 20'd0, loop_end: 20'd0, kind: KIND_NONE},
                20'd3, 24'h018000);
    queue_request(1'b1, 1'b0);
    repeat (3) queue_request(1'b0, 1'b0);

    // overshort bidirectional loop at the top of the range, top saturation on release
    apply_setup('{loop_start: 20'hFFFFF, loop_end: 20'd4, kind: KIND_BIDIR},
                '{loop_start: 20'd0, loop_end: 20'd0, kind: KIND_RESERVED},
                20'hFFFFF, 24'hFFFFFF);
    queue_request(1'b1, 1'b1);
    repeat (2) queue_request(1'b0, 1'b0);
    repeat (2) queue_request(1'b0, 1'b1);

    // forward wrap, switch to the second loop on release, reflect at its end
    apply_setup('{loop_start: 20'd2, loop_end: 20'd5, kind: KIND_FORWARD},
                '{loop_start: 20'd4, loop_end: 20'd6, kind: KIND_BIDIR},
                20'd8, 24'h014000);
    queue_request(1'b1, 1'b0);
    repeat (4) queue_request(1'b0, 1'b0);
    repeat (4) queue_request(1'b0, 1'b1);

    // one-frame bidirectional loop at zero: reflect at both loop ends
    apply_setup('{loop_start: 20'd0, loop_end: 20'd1, kind: KIND_BIDIR},
                '{loop_start: 20'd0, loop_end: 20'd1, kind: KIND_FORWARD},
                20'd1, 24'h010000);
    queue_request(1'b1, 1'b0);
    repeat (3) queue_request(1'b0, 1'b0);

    for (int phase = 0; phase < 15; phase++) begin
      random_setup();
      case (phase)
        2: begin
          sender_steady   <= 1'b1;
          receiver_steady <= 1'b1;
          queue_voice_run(70);
          wait_drained();
          sender_steady   <= 1'b0;
          receiver_steady <= 1'b0;
        end
        5: begin
          sender_steady <= 1'b1;
          queue_voice_run(70);
          long_hold_req <= 1'b1;
          @(negedge clk_i);
          long_hold_req <= 1'b0;
          wait_drained();
          sender_steady <= 1'b0;
        end
        9: begin
          queue_voice_run(35);
          while (queued_requests.size() > 10) @(negedge clk_i);
          sender_hold <= 1'b1;
          @(negedge clk_i);
          while (in_valid_i || predicted_pointers.size() != 0) @(negedge clk_i);
          repeat (5) @(negedge clk_i);
          sender_hold <= 1'b0;
          queue_voice_run(35);
        end
        default: queue_voice_run(70);
      endcase
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("%0d pointer transactions in, %0d results checked over 20 register settings",
             requests_accepted, results_checked);
    $display("loop events %0d, reversed %0d, second loop %0d, finished %0d",
             boundary_events, reversed_seen, second_loop_seen, finished_seen);
    if (mismatch_count == 0) begin
      $display("sample_loop_position_engine_core_test: done, clean");
    end else begin
      $display("sample_loop_position_engine_core_test: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/slpe_pkg.sv
hdl/slpe_update.sv
hdl/sample_loop_position_engine_core.sv
tb/sv/sample_loop_position_engine_core_test.sv
